[rtl/core/xmbr_pkg.sv]
// ----------------------------------------------------------------------------
// xmbr_pkg - XMODEM block receiver package
// Phase encoding, reply and status codes, line characters and the CRC-16 step.
// ----------------------------------------------------------------------------
package xmbr_pkg;

  // Line control characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_CAN = 8'h18;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [8:0]  COMPL_SUM = 9'd255;

  // Input operations
  typedef enum logic {
    OP_START = 1'b0,
    OP_BYTE  = 1'b1
  } op_t;

  // Reply codes
  typedef enum logic [2:0] {
    R_NONE = 3'd0,
    R_ACK  = 3'd1,
    R_NAK  = 3'd2,
    R_C    = 3'd3,
    R_CAN8 = 3'd4
  } reply_t;

  // Transfer status codes
  typedef enum logic [2:0] {
    ST_RUNNING   = 3'd0,
    ST_DONE      = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_ERR_LIMIT = 3'd3,
    ST_BAD_BLOCK = 3'd4,
    ST_STRAY     = 3'd5
  } status_t;

  // Framing phase
  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_NUMBER    = 3'd1,
    PH_COMPL     = 3'd2,
    PH_DATA      = 3'd3,
    PH_CHECK_HI  = 3'd4,
    PH_CHECK_LO  = 3'd5,
    PH_AFTER_EOT = 3'd6,
    PH_AFTER_CAN = 3'd7
  } phase_t;

  // Configuration register indexes
  typedef enum logic {
    REG_CRC_MODE    = 1'b0,
    REG_ERROR_LIMIT = 1'b1
  } reg_idx_t;

  // One byte through the CRC-16 (MSB first, no reflection)
  function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

[rtl/core/xmodem_block_receiver.sv]
// ----------------------------------------------------------------------------
// xmodem_block_receiver - XMODEM receiver, one line byte per request
// Frames SOH blocks, checks CRC-16 or 8-bit sum, streams data bytes with
// their index and gives an ACK/NAK/cancel verdict at block end.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Handshake          | Payload
//  ---------+-----+--------------------+-------------------------------------
//  in       | in  | in_valid/in_stall  | op, rx_byte
//  out      | out | out_valid/out_stall| reply, data_valid, data_byte,
//           |     |                    | data_index, block_commit,
//           |     |                    | block_discard, status
//  config   | in  | APB (psel/penable) | crc_mode @0x0, error_limit @0x4
//
// One request per cycle sustained while the result side is not stalled; each
// request passes the input register, then the result register, on its way out.
// The transfer state is updated as a request moves from the input register
// into the result register, so each decision is a single pass of logic.
// A stalled result holds in the output register while one more request waits
// in the input register; in_stall rises only when both are full.
// Synchronous reset; no clearing pass is needed.

module xmodem_block_receiver #(
  parameter int BLOCK_DATA_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  reply,
  output logic        data_valid,
  output logic [7:0]  data_byte,
  output logic [6:0]  data_index,
  output logic        block_commit,
  output logic        block_discard,
  output logic [2:0]  status
);

  localparam int POS_W = $clog2(BLOCK_DATA_BYTES + 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_DATA_BYTES);

  // configuration registers
  logic       crc_mode;
  logic [7:0] error_limit;

  // input register
  logic       s1_valid;
  logic       s1_op;
  logic [7:0] s1_byte;

  // transfer state
  xmbr_pkg::phase_t  phase, phase_next;
  xmbr_pkg::status_t final_status, final_status_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [7:0]        block_number, block_number_next;
  logic [7:0]        block_complement, block_complement_next;
  logic [15:0]       running_check, running_check_next;
  logic [15:0]       received_check, received_check_next;
  logic [7:0]        last_good_number, last_good_number_next;
  logic [7:0]        error_count, error_count_next;

  // result of the request in the input register
  xmbr_pkg::reply_t  r_reply;
  xmbr_pkg::status_t r_status;
  logic              r_data_valid;
  logic [7:0]        r_data_byte;
  logic [6:0]        r_data_index;
  logic              r_commit;
  logic              r_discard;

  logic accept;
  logic advance;
  logic cfg_write;

  // block-end helpers
  logic [15:0] check_eff;
  logic [7:0]  next_number;
  logic [8:0]  compl_sum;
  logic [7:0]  count_inc;
  logic [POS_W-1:0] pos_inc;
  logic        finish;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode    <= 1'b1;
      error_limit <= 8'd10;
    end else if (cfg_write) begin
      unique case (xmbr_pkg::reg_idx_t'(paddr[2]))
        xmbr_pkg::REG_CRC_MODE:    crc_mode    <= pwdata[0];
        xmbr_pkg::REG_ERROR_LIMIT: error_limit <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (xmbr_pkg::reg_idx_t'(paddr[2]))
      xmbr_pkg::REG_CRC_MODE:    prdata = {31'd0, crc_mode};
      xmbr_pkg::REG_ERROR_LIMIT: prdata = {24'd0, error_limit};
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= op;
      s1_byte <= rx_byte;
    end
  end

  // --------------------------------------------------------------------------
  // State register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= xmbr_pkg::PH_HEADER;
      final_status     <= xmbr_pkg::ST_RUNNING;
      byte_position    <= '0;
      block_number     <= 8'd0;
      block_complement <= 8'd0;
      running_check    <= 16'd0;
      received_check   <= 16'd0;
      last_good_number <= 8'd0;
      error_count      <= 8'd0;
    end else if (advance) begin
      phase            <= phase_next;
      final_status     <= final_status_next;
      byte_position    <= byte_position_next;
      block_number     <= block_number_next;
      block_complement <= block_complement_next;
      running_check    <= running_check_next;
      received_check   <= received_check_next;
      last_good_number <= last_good_number_next;
      error_count      <= error_count_next;
    end
  end

  // --------------------------------------------------------------------------
  // Next state and result
  // --------------------------------------------------------------------------
  assign next_number = last_good_number + 8'd1;
  assign compl_sum   = {1'b0, block_number} + {1'b0, block_complement};
  assign count_inc   = (error_count == 8'hFF) ? error_count : error_count + 8'd1;
  assign pos_inc     = byte_position + POS_W'(1);
  // check bytes as they stand once the last one is in
  assign check_eff   = (phase == xmbr_pkg::PH_CHECK_LO) ? (received_check | {8'd0, s1_byte})
                                                        : {8'd0, s1_byte};

  always_comb begin
    phase_next            = phase;
    final_status_next     = final_status;
    byte_position_next    = byte_position;
    block_number_next     = block_number;
    block_complement_next = block_complement;
    running_check_next    = running_check;
    received_check_next   = received_check;
    last_good_number_next = last_good_number;
    error_count_next      = error_count;

    r_reply      = xmbr_pkg::R_NONE;
    r_status     = xmbr_pkg::ST_RUNNING;
    r_data_valid = 1'b0;
    r_data_byte  = 8'd0;
    r_data_index = 7'd0;
    r_commit     = 1'b0;
    r_discard    = 1'b0;
    finish       = 1'b0;

    if (xmbr_pkg::op_t'(s1_op) == xmbr_pkg::OP_START) begin
      phase_next            = xmbr_pkg::PH_HEADER;
      final_status_next     = xmbr_pkg::ST_RUNNING;
      byte_position_next    = '0;
      block_number_next     = 8'd0;
      block_complement_next = 8'd0;
      running_check_next    = 16'd0;
      received_check_next   = 16'd0;
      last_good_number_next = 8'd0;
      error_count_next      = 8'd0;
      r_reply = crc_mode ? xmbr_pkg::R_C : xmbr_pkg::R_NAK;
    end else if (final_status != xmbr_pkg::ST_RUNNING) begin
      // stopped: repeat the final status until the next start
      r_status = final_status;
    end else begin
      unique case (phase)
        xmbr_pkg::PH_HEADER: begin
          priority if (s1_byte == xmbr_pkg::CH_SOH) begin
            phase_next = xmbr_pkg::PH_NUMBER;
          end else if (s1_byte == xmbr_pkg::CH_EOT) begin
            r_reply    = xmbr_pkg::R_NAK;
            phase_next = xmbr_pkg::PH_AFTER_EOT;
          end else if (s1_byte == xmbr_pkg::CH_CAN) begin
            r_reply    = xmbr_pkg::R_NAK;
            phase_next = xmbr_pkg::PH_AFTER_CAN;
          end else begin
            final_status_next = xmbr_pkg::ST_STRAY;
            r_status          = xmbr_pkg::ST_STRAY;
          end
        end
        xmbr_pkg::PH_NUMBER: begin
          block_number_next = s1_byte;
          phase_next        = xmbr_pkg::PH_COMPL;
        end
        xmbr_pkg::PH_COMPL: begin
          block_complement_next = s1_byte;
          byte_position_next    = '0;
          running_check_next    = 16'd0;
          received_check_next   = 16'd0;
          phase_next            = xmbr_pkg::PH_DATA;
        end
        xmbr_pkg::PH_DATA: begin
          r_data_valid = 1'b1;
          r_data_byte  = s1_byte;
          r_data_index = byte_position[6:0];
          if (crc_mode) begin
            running_check_next = xmbr_pkg::crc16_update(running_check, s1_byte);
          end else begin
            running_check_next = {8'd0, running_check[7:0] + s1_byte};
          end
          byte_position_next = pos_inc;
          if (pos_inc >= POS_LAST) begin
            phase_next = xmbr_pkg::PH_CHECK_HI;
          end
        end
        xmbr_pkg::PH_CHECK_HI: begin
          if (crc_mode) begin
            received_check_next = {s1_byte, 8'd0};
            phase_next          = xmbr_pkg::PH_CHECK_LO;
          end else begin
            received_check_next = check_eff;
            finish              = 1'b1;
          end
        end
        xmbr_pkg::PH_CHECK_LO: begin
          received_check_next = check_eff;
          finish              = 1'b1;
        end
        xmbr_pkg::PH_AFTER_EOT: begin
          priority if (s1_byte == xmbr_pkg::CH_EOT) begin
            r_reply           = xmbr_pkg::R_ACK;
            final_status_next = xmbr_pkg::ST_DONE;
            r_status          = xmbr_pkg::ST_DONE;
          end else if (s1_byte == xmbr_pkg::CH_SOH) begin
            phase_next = xmbr_pkg::PH_NUMBER;
          end else begin
            final_status_next = xmbr_pkg::ST_STRAY;
            r_status          = xmbr_pkg::ST_STRAY;
          end
        end
        xmbr_pkg::PH_AFTER_CAN: begin
          priority if (s1_byte == xmbr_pkg::CH_CAN) begin
            final_status_next = xmbr_pkg::ST_CANCELLED;
            r_status          = xmbr_pkg::ST_CANCELLED;
          end else if (s1_byte == xmbr_pkg::CH_SOH) begin
            phase_next = xmbr_pkg::PH_NUMBER;
          end else if (s1_byte == xmbr_pkg::CH_EOT) begin
            r_reply    = xmbr_pkg::R_NAK;
            phase_next = xmbr_pkg::PH_AFTER_EOT;
          end else begin
            final_status_next = xmbr_pkg::ST_STRAY;
            r_status          = xmbr_pkg::ST_STRAY;
          end
        end
      endcase

      // block verdict: complement, then window, then error limit, then check bytes
      if (finish) begin
        phase_next = xmbr_pkg::PH_HEADER;
        priority if (compl_sum != xmbr_pkg::COMPL_SUM) begin
          if (error_count > error_limit) begin
            r_reply           = xmbr_pkg::R_CAN8;
            r_discard         = 1'b1;
            final_status_next = xmbr_pkg::ST_ERR_LIMIT;
            r_status          = xmbr_pkg::ST_ERR_LIMIT;
          end else begin
            r_reply          = xmbr_pkg::R_NAK;
            r_discard        = 1'b1;
            error_count_next = count_inc;
          end
        end else if (block_number != last_good_number && block_number != next_number) begin
          r_reply           = xmbr_pkg::R_CAN8;
          r_discard         = 1'b1;
          final_status_next = xmbr_pkg::ST_BAD_BLOCK;
          r_status          = xmbr_pkg::ST_BAD_BLOCK;
        end else if (error_count > error_limit) begin
          r_reply           = xmbr_pkg::R_CAN8;
          r_discard         = 1'b1;
          final_status_next = xmbr_pkg::ST_ERR_LIMIT;
          r_status          = xmbr_pkg::ST_ERR_LIMIT;
        end else if (running_check != check_eff) begin
          r_reply          = xmbr_pkg::R_NAK;
          r_discard        = 1'b1;
          error_count_next = count_inc;
        end else if (block_number == last_good_number) begin
          // good copy of a block already kept
          r_reply          = xmbr_pkg::R_ACK;
          r_discard        = 1'b1;
          error_count_next = count_inc;
        end else begin
          r_reply               = xmbr_pkg::R_ACK;
          r_commit              = 1'b1;
          error_count_next      = 8'd0;
          last_good_number_next = block_number;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      reply         <= r_reply;
      data_valid    <= r_data_valid;
      data_byte     <= r_data_byte;
      data_index    <= r_data_index;
      block_commit  <= r_commit;
      block_discard <= r_discard;
      status        <= r_status;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("request stalled with room in the pipeline");

  a_data_no_verdict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && data_valid) |-> (!block_commit && !block_discard
                                   && reply == xmbr_pkg::R_NONE))
    else $error("data byte carries a reply or verdict");

  a_commit_is_ack: assert property (@(posedge clk) disable iff (rst)
    (out_valid && block_commit) |-> (reply == xmbr_pkg::R_ACK && !block_discard
                                     && status == xmbr_pkg::ST_RUNNING))
    else $error("committed block without a plain ACK");

  a_commit_clears_count: assert property (@(posedge clk) disable iff (rst)
    (advance && r_commit) |=> (error_count == 8'd0))
    else $error("error count not cleared after a new good block");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the XMODEM block receiver
// Drives line bytes and start requests with random sender bursts and receiver
// stalls. Each accepted request is run through a local model of the receiver,
// and the verdicts it gives are compared field by field, in order, with the
// results that come out. A short directed run covers the line controls; then
// random transfers, some with blocks cut short, under several register settings.
// ----------------------------------------------------------------------------
module tb;

  localparam int DATA_BYTES = 128;

  typedef struct packed {
    xmbr_pkg::reply_t  reply;
    logic              data_valid;
    logic [7:0]        data_byte;
    logic [6:0]        data_index;
    logic              block_commit;
    logic              block_discard;
    xmbr_pkg::status_t status;
  } line_result_t;

  typedef enum int {
    BK_GOOD,
    BK_DUP,
    BK_BAD_CHECK,
    BK_BAD_COMPL,
    BK_OUTSIDE,
    BK_CUT
  } blk_kind_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         in_valid = 1'b0;
  logic         in_stall;
  xmbr_pkg::op_t op = xmbr_pkg::OP_START;
  logic [7:0]   rx_byte = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [2:0]   reply;
  logic         data_valid;
  logic [7:0]   data_byte;
  logic [6:0]   data_index;
  logic         block_commit;
  logic         block_discard;
  logic [2:0]   status;

  // register mirror
  logic        cfg_crc = 1'b1;
  logic [7:0]  cfg_limit = 8'd10;

  // receiver state as predicted
  xmbr_pkg::phase_t  rcv_phase = xmbr_pkg::PH_HEADER;
  logic [10:0]       rcv_pos = '0;
  logic [7:0]        rcv_num = '0;
  logic [7:0]        rcv_cpl = '0;
  logic [15:0]       rcv_run = '0;
  logic [15:0]       rcv_got = '0;
  logic [7:0]        rcv_last_good = '0;
  logic [7:0]        rcv_errs = '0;
  xmbr_pkg::status_t rcv_final = xmbr_pkg::ST_RUNNING;

  line_result_t line_results_q[$];

  int mismatches = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_commits = 0;
  int n_discards = 0;
  int burst_left = 8;
  int stall_mode = 0;
  int stall_hold = 0;

  xmodem_block_receiver #(
    .BLOCK_DATA_BYTES(DATA_BYTES)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .reply         (reply),
    .data_valid    (data_valid),
    .data_byte     (data_byte),
    .data_index    (data_index),
    .block_commit  (block_commit),
    .block_discard (block_discard),
    .status        (status)
  );

  always #10 clk = ~clk;

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report(input string what, input int seen, input int wanted);
    mismatches++;
    if (mismatches <= 30) begin
      $display("ERROR @%0t: %s got %0d wanted %0d", $time, what, seen, wanted);
    end
  endtask

  // --------------------------------------------------------------------------
  // Model of the receiver
  // --------------------------------------------------------------------------
  function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = c;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ b[i];
      acc = {acc[14:0], 1'b0} ^ (fb ? xmbr_pkg::CRC_POLY : 16'h0000);
    end
    return acc;
  endfunction

  function automatic void bump_errors();
    if (rcv_errs != 8'hFF) rcv_errs++;
  endfunction

  function automatic line_result_t close_block(input line_result_t r_in);
    line_result_t r;
    logic [7:0]   seq_next;
    logic         good;
    logic         fresh;
    r        = r_in;
    seq_next = rcv_last_good + 8'd1;
    good     = 1'b1;
    fresh    = 1'b1;
    rcv_phase = xmbr_pkg::PH_HEADER;
    if ({1'b0, rcv_num} + {1'b0, rcv_cpl} != xmbr_pkg::COMPL_SUM) begin
      good  = 1'b0;
      fresh = 1'b0;
    end else if (rcv_num != rcv_last_good && rcv_num != seq_next) begin
      r.reply         = xmbr_pkg::R_CAN8;
      r.block_discard = 1'b1;
      rcv_final       = xmbr_pkg::ST_BAD_BLOCK;
      r.status        = xmbr_pkg::ST_BAD_BLOCK;
      return r;
    end else begin
      if (rcv_num == rcv_last_good) fresh = 1'b0;
      if (rcv_run != rcv_got) begin
        good  = 1'b0;
        fresh = 1'b0;
      end
    end
    // count is tested before it is raised
    if (rcv_errs > cfg_limit) begin
      r.reply         = xmbr_pkg::R_CAN8;
      r.block_discard = 1'b1;
      rcv_final       = xmbr_pkg::ST_ERR_LIMIT;
      r.status        = xmbr_pkg::ST_ERR_LIMIT;
      return r;
    end
    if (good) begin
      r.reply = xmbr_pkg::R_ACK;
      if (fresh) begin
        rcv_errs       = '0;
        rcv_last_good  = rcv_num;
        r.block_commit = 1'b1;
      end else begin
        bump_errors();
        r.block_discard = 1'b1;
      end
    end else begin
      r.reply = xmbr_pkg::R_NAK;
      bump_errors();
      r.block_discard = 1'b1;
    end
    return r;
  endfunction

  function automatic line_result_t receiver_step(input xmbr_pkg::op_t o,
                                                 input logic [7:0] b);
    line_result_t r;
    r = '0;
    r.reply  = xmbr_pkg::R_NONE;
    r.status = xmbr_pkg::ST_RUNNING;
    if (o == xmbr_pkg::OP_START) begin
      rcv_phase     = xmbr_pkg::PH_HEADER;
      rcv_pos       = '0;
      rcv_num       = '0;
      rcv_cpl       = '0;
      rcv_run       = '0;
      rcv_got       = '0;
      rcv_last_good = '0;
      rcv_errs      = '0;
      rcv_final     = xmbr_pkg::ST_RUNNING;
      r.reply = cfg_crc ? xmbr_pkg::R_C : xmbr_pkg::R_NAK;
      return r;
    end
    if (rcv_final != xmbr_pkg::ST_RUNNING) begin
      r.status = rcv_final;
      return r;
    end
    case (rcv_phase)
      xmbr_pkg::PH_HEADER: begin
        if (b == xmbr_pkg::CH_SOH) begin
          rcv_phase = xmbr_pkg::PH_NUMBER;
        end else if (b == xmbr_pkg::CH_EOT) begin
          r.reply   = xmbr_pkg::R_NAK;
          rcv_phase = xmbr_pkg::PH_AFTER_EOT;
        end else if (b == xmbr_pkg::CH_CAN) begin
          r.reply   = xmbr_pkg::R_NAK;
          rcv_phase = xmbr_pkg::PH_AFTER_CAN;
        end else begin
          rcv_final = xmbr_pkg::ST_STRAY;
          r.status  = xmbr_pkg::ST_STRAY;
        end
      end
      xmbr_pkg::PH_NUMBER: begin
        rcv_num   = b;
        rcv_phase = xmbr_pkg::PH_COMPL;
      end
      xmbr_pkg::PH_COMPL: begin
        rcv_cpl   = b;
        rcv_pos   = '0;
        rcv_run   = '0;
        rcv_got   = '0;
        rcv_phase = xmbr_pkg::PH_DATA;
      end
      xmbr_pkg::PH_DATA: begin
        r.data_valid = 1'b1;
        r.data_byte  = b;
        r.data_index = rcv_pos[6:0];
        if (cfg_crc) rcv_run = crc_fold(rcv_run, b);
        else rcv_run = {8'd0, rcv_run[7:0] + b};
        rcv_pos++;
        if (rcv_pos >= DATA_BYTES) rcv_phase = xmbr_pkg::PH_CHECK_HI;
      end
      xmbr_pkg::PH_CHECK_HI: begin
        if (cfg_crc) begin
          rcv_got   = {b, 8'd0};
          rcv_phase = xmbr_pkg::PH_CHECK_LO;
        end else begin
          rcv_got = {8'd0, b};
          r = close_block(r);
        end
      end
      xmbr_pkg::PH_CHECK_LO: begin
        rcv_got = {rcv_got[15:8], b};
        r = close_block(r);
      end
      xmbr_pkg::PH_AFTER_EOT: begin
        if (b == xmbr_pkg::CH_EOT) begin
          r.reply   = xmbr_pkg::R_ACK;
          rcv_final = xmbr_pkg::ST_DONE;
          r.status  = xmbr_pkg::ST_DONE;
        end else if (b == xmbr_pkg::CH_SOH) begin
          rcv_phase = xmbr_pkg::PH_NUMBER;
        end else begin
          rcv_final = xmbr_pkg::ST_STRAY;
          r.status  = xmbr_pkg::ST_STRAY;
        end
      end
      default: begin
        if (b == xmbr_pkg::CH_CAN) begin
          rcv_final = xmbr_pkg::ST_CANCELLED;
          r.status  = xmbr_pkg::ST_CANCELLED;
        end else if (b == xmbr_pkg::CH_SOH) begin
          rcv_phase = xmbr_pkg::PH_NUMBER;
        end else if (b == xmbr_pkg::CH_EOT) begin
          r.reply   = xmbr_pkg::R_NAK;
          rcv_phase = xmbr_pkg::PH_AFTER_EOT;
        end else begin
          rcv_final = xmbr_pkg::ST_STRAY;
          r.status  = xmbr_pkg::ST_STRAY;
        end
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  task automatic push_request(input xmbr_pkg::op_t o, input logic [7:0] b);
    in_valid <= 1'b1;
    op       <= o;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    line_results_q.push_back(receiver_step(o, b));
    n_accepted++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic apb_write(input xmbr_pkg::reg_idx_t idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic apb_check(input xmbr_pkg::reg_idx_t idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== v) report("register readback", prdata, v);
  endtask

  task automatic set_config(input logic crc, input logic [7:0] lim);
    apb_write(xmbr_pkg::REG_CRC_MODE, {31'd0, crc});
    apb_write(xmbr_pkg::REG_ERROR_LIMIT, {24'd0, lim});
    apb_check(xmbr_pkg::REG_CRC_MODE, {31'd0, crc});
    apb_check(xmbr_pkg::REG_ERROR_LIMIT, {24'd0, lim});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_crc   = crc;
    cfg_limit = lim;
  endtask

  task automatic settle();
    int spins;
    spins = 0;
    in_valid <= 1'b0;
    while (line_results_q.size() != 0 && spins < 50000) begin
      @(posedge clk);
      spins++;
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] stray_byte();
    logic [7:0] s;
    s = 8'($urandom_range(0, 255));
    while (s == xmbr_pkg::CH_SOH || s == xmbr_pkg::CH_EOT || s == xmbr_pkg::CH_CAN) begin
      s = 8'($urandom_range(0, 255));
    end
    return s;
  endfunction

  task automatic send_block(input blk_kind_t kind);
    logic [7:0]  num;
    logic [7:0]  cpl;
    logic [7:0]  d;
    logic [15:0] chk;
    int          n;
    case (kind)
      BK_DUP:     num = rcv_last_good;
      BK_OUTSIDE: num = rcv_last_good + 8'($urandom_range(2, 255));
      default:    num = rcv_last_good + 8'd1;
    endcase
    cpl = ~num;
    if (kind == BK_BAD_COMPL) cpl = cpl ^ 8'($urandom_range(1, 255));
    push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_SOH);
    push_request(xmbr_pkg::OP_BYTE, num);
    push_request(xmbr_pkg::OP_BYTE, cpl);
    chk = '0;
    n = (kind == BK_CUT) ? $urandom_range(0, DATA_BYTES - 1) : DATA_BYTES;
    for (int i = 0; i < n; i++) begin
      d = 8'($urandom_range(0, 255));
      if (cfg_crc) chk = crc_fold(chk, d);
      else chk = {8'd0, chk[7:0] + d};
      push_request(xmbr_pkg::OP_BYTE, d);
    end
    if (kind != BK_CUT) begin
      if (kind == BK_BAD_CHECK) begin
        chk = chk ^ (cfg_crc ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 255)));
      end
      if (cfg_crc) push_request(xmbr_pkg::OP_BYTE, chk[15:8]);
      push_request(xmbr_pkg::OP_BYTE, chk[7:0]);
    end
  endtask

  task automatic run_transfers(input int budget);
    int first;
    int nblk;
    int pick;
    int done_blk;
    first = n_accepted;
    while (n_accepted - first < budget) begin
      push_request(xmbr_pkg::OP_START, 8'($urandom_range(0, 255)));
      nblk = $urandom_range(1, 5);
      done_blk = 0;
      while (done_blk < nblk && rcv_final == xmbr_pkg::ST_RUNNING) begin
        // a lone EOT or CAN may sit before a block
        pick = $urandom_range(0, 9);
        if (pick == 0) push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_EOT);
        else if (pick == 1) push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_CAN);
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
          send_block(BK_GOOD);
        end else if (pick < 13) begin
          send_block(BK_DUP);
        end else if (pick < 15) begin
          send_block(BK_BAD_CHECK);
        end else if (pick < 17) begin
          send_block(BK_BAD_COMPL);
        end else if (pick == 17) begin
          send_block(BK_OUTSIDE);
        end else if (pick == 18) begin
          send_block(BK_CUT);
          push_request(xmbr_pkg::OP_START, 8'($urandom_range(0, 255)));
        end else begin
          push_request(xmbr_pkg::OP_BYTE, stray_byte());
        end
        done_blk++;
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_EOT);
        push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_EOT);
      end else if (pick < 8) begin
        push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_CAN);
        push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_CAN);
      end else if (pick == 8) begin
        push_request(xmbr_pkg::OP_BYTE, stray_byte());
      end
      repeat ($urandom_range(0, 2)) begin
        push_request(xmbr_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
      end
    end
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_line_controls();
    push_request(xmbr_pkg::OP_BYTE, 8'hFF);            // no start yet: stray header
    push_request(xmbr_pkg::OP_BYTE, 8'h00);            // stopped, status repeats
    push_request(xmbr_pkg::OP_START, 8'hA5);
    push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_EOT);
    push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_EOT);
    push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_SOH); // done, no framing any more
    push_request(xmbr_pkg::OP_START, 8'h5A);
    push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_CAN);
    push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_EOT); // after CAN acts as a first EOT
    push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_CAN); // stray after EOT
    push_request(xmbr_pkg::OP_START, 8'h00);
    push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_CAN);
    push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_CAN);
    push_request(xmbr_pkg::OP_START, 8'hFF);
    push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_CAN);
    push_request(xmbr_pkg::OP_BYTE, 8'h7E);            // stray after CAN
    push_request(xmbr_pkg::OP_START, 8'h00);
    push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_EOT);
    push_request(xmbr_pkg::OP_BYTE, 8'h80);
    push_request(xmbr_pkg::OP_START, 8'h00);
    push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_CAN);
    push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_SOH); // block may follow a CAN
    push_request(xmbr_pkg::OP_BYTE, 8'h00);
    push_request(xmbr_pkg::OP_BYTE, 8'hFF);
    settle();
  endtask

  task automatic test_crc_transfers();
    run_transfers(200);
  endtask

  task automatic test_sum_transfers();
    set_config(1'b0, 8'd250);
    run_transfers(150);
  endtask

  task automatic test_error_limit(input logic crc, input logic [7:0] lim);
    int tries;
    int pick;
    set_config(crc, lim);
    push_request(xmbr_pkg::OP_START, 8'($urandom_range(0, 255)));
    send_block(BK_GOOD);
    tries = 0;
    while (rcv_final == xmbr_pkg::ST_RUNNING && tries < 8) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) send_block(BK_BAD_CHECK);
      else if (pick == 1) send_block(BK_BAD_COMPL);
      else send_block(BK_DUP);
      tries++;
    end
    push_request(xmbr_pkg::OP_BYTE, xmbr_pkg::CH_EOT);
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_line_controls();
    test_crc_transfers();
    test_sum_transfers();
    test_error_limit(1'b1, 8'd0);
    test_error_limit(1'b0, 8'd1);
    set_config(1'b1, 8'd10);
    run_transfers(50);
    if (line_results_q.size() != 0) report("results never produced", line_results_q.size(), 0);
    $display("Covered %0d requests, %0d results checked, %0d blocks kept, %0d dropped.",
             n_accepted, n_checked, n_commits, n_discards);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_hold = $urandom_range(16, 160);
    end else begin
      stall_hold--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 7) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ((stall_hold % 6) < 3);
    endcase
  end

  always @(posedge clk) begin
    line_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (line_results_q.size() == 0) begin
        report("result with no request pending", reply, 0);
      end else begin
        want = line_results_q.pop_front();
        n_checked++;
        if (want.block_commit) n_commits++;
        if (want.block_discard) n_discards++;
        if (reply !== want.reply) report("reply", reply, want.reply);
        if (data_valid !== want.data_valid) report("data_valid", data_valid, want.data_valid);
        if (data_byte !== want.data_byte) report("data_byte", data_byte, want.data_byte);
        if (data_index !== want.data_index) report("data_index", data_index, want.data_index);
        if (block_commit !== want.block_commit) begin
          report("block_commit", block_commit, want.block_commit);
        end
        if (block_discard !== want.block_discard) begin
          report("block_discard", block_discard, want.block_discard);
        end
        if (status !== want.status) report("status", status, want.status);
      end
    end
  end

endmodule
